/* hdl/serial_packet_deframer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the serial packet deframer
// Shorthand for clocked checks that are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SERIAL_PACKET_DEFRAMER_ASSERT_SVH
`define SERIAL_PACKET_DEFRAMER_ASSERT_SVH

// condition holds at every edge outside reset
`define SPD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("spd check failed");

// antecedent implies consequent in the same cycle
`define SPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spd check failed");

`endif

/* hdl/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg
// Types and constants shared by the serial packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int unsigned LEN_W = 11;
  localparam int unsigned CNT_W = 16;
  localparam logic [LEN_W-1:0] MAX_PACKET = 11'd1024;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [7:0] REQUEST_RESET = 8'd1;
  localparam logic [7:0] ACK_RESET     = 8'd2;
  localparam logic [7:0] END_RESET     = 8'd3;
  localparam logic [7:0] ESCAPE_RESET  = 8'd4;

  typedef enum logic [1:0] {
    REG_REQUEST = 2'd0,
    REG_ACK     = 2'd1,
    REG_END     = 2'd2,
    REG_ESCAPE  = 2'd3
  } spd_reg_t;

  typedef struct packed {
    logic [7:0] request_code;
    logic [7:0] ack_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
  } spd_codes_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  rx_byte;
    logic        buffer_free;
    logic [31:0] tick_now;
  } spd_item_t;

  typedef struct packed {
    logic             write_valid;
    logic [7:0]       data_byte;
    logic             packet_done;
    logic [LEN_W-1:0] length;
    logic [31:0]      stamp;
    logic             send_ack;
    logic             ack_flag;
    logic [CNT_W-1:0] count_received;
    logic [CNT_W-1:0] count_dropped;
    logic [CNT_W-1:0] count_escapes;
    logic [CNT_W-1:0] count_req_inside;
    logic [CNT_W-1:0] count_refused;
  } spd_result_t;

endpackage

/* hdl/spd_cfg.sv */
// ----------------------------------------------------------------------------
// spd_cfg
// Code byte registers behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module spd_cfg
  import spd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output spd_codes_t  codes
);

  spd_reg_t sel;
  logic     wr;

  assign sel    = spd_reg_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.request_code <= REQUEST_RESET;
      codes.ack_code     <= ACK_RESET;
      codes.end_code     <= END_RESET;
      codes.escape_code  <= ESCAPE_RESET;
    end else if (wr) begin
      case (sel)
        REG_REQUEST: codes.request_code <= pwdata[7:0];
        REG_ACK:     codes.ack_code     <= pwdata[7:0];
        REG_END:     codes.end_code     <= pwdata[7:0];
        REG_ESCAPE:  codes.escape_code  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_REQUEST: prdata = {24'd0, codes.request_code};
      REG_ACK:     prdata = {24'd0, codes.ack_code};
      REG_END:     prdata = {24'd0, codes.end_code};
      REG_ESCAPE:  prdata = {24'd0, codes.escape_code};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

/* hdl/spd_core.sv */
// ----------------------------------------------------------------------------
// spd_core
// Framing state and counters; decodes one request per fire.
// ----------------------------------------------------------------------------
module spd_core
  import spd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  spd_codes_t  codes,
  input  spd_item_t   item,
  output spd_result_t res
);

  logic             busy, busy_next;
  logic             escape_pending, escape_pending_next;
  logic             ack_seen, ack_seen_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [CNT_W-1:0] received_total, received_total_next;
  logic [CNT_W-1:0] dropped_total, dropped_total_next;
  logic [CNT_W-1:0] escape_total, escape_total_next;
  logic [CNT_W-1:0] req_inside_total, req_inside_total_next;
  logic [CNT_W-1:0] refused_total, refused_total_next;
  logic [7:0]       decoded;
  logic             wr, done, ack_out;

  always_comb begin
    busy_next             = busy;
    escape_pending_next   = escape_pending;
    ack_seen_next         = ack_seen;
    byte_count_next       = byte_count;
    received_total_next   = received_total;
    dropped_total_next    = dropped_total;
    escape_total_next     = escape_total;
    req_inside_total_next = req_inside_total;
    refused_total_next    = refused_total;
    wr      = 1'b0;
    done    = 1'b0;
    ack_out = 1'b0;
    decoded = escape_pending ? 8'(codes.escape_code + item.rx_byte) : item.rx_byte;

    if (item.operation == OP_CLEAR) begin
      ack_seen_next = 1'b0;
    end else if (item.rx_byte == codes.request_code) begin
      if (busy) begin
        req_inside_total_next = req_inside_total + 16'd1;
        dropped_total_next    = dropped_total + 16'd1;
        byte_count_next       = '0;
        ack_out               = 1'b1;
      end else if (item.buffer_free) begin
        busy_next       = 1'b1;
        byte_count_next = '0;
        ack_out         = 1'b1;
      end else begin
        refused_total_next = refused_total + 16'd1;
      end
    end else if (item.rx_byte == codes.ack_code) begin
      ack_seen_next = 1'b1;
    end else if (!busy) begin
      // drop bytes outside a packet
    end else if (item.rx_byte == codes.end_code) begin
      done                = 1'b1;
      busy_next           = 1'b0;
      received_total_next = received_total + 16'd1;
    end else if (item.rx_byte == codes.escape_code) begin
      escape_pending_next = 1'b1;
      escape_total_next   = escape_total + 16'd1;
    end else begin
      escape_pending_next = 1'b0;
      if (byte_count < MAX_PACKET) begin
        byte_count_next = byte_count + 11'd1;
        wr              = 1'b1;
      end
    end

    res.write_valid      = wr;
    res.data_byte        = wr ? decoded : 8'd0;
    res.packet_done      = done;
    res.length           = byte_count_next;
    res.stamp            = done ? item.tick_now : 32'd0;
    res.send_ack         = ack_out;
    res.ack_flag         = ack_seen_next;
    res.count_received   = received_total_next;
    res.count_dropped    = dropped_total_next;
    res.count_escapes    = escape_total_next;
    res.count_req_inside = req_inside_total_next;
    res.count_refused    = refused_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      escape_pending   <= 1'b0;
      ack_seen         <= 1'b0;
      byte_count       <= '0;
      received_total   <= '0;
      dropped_total    <= '0;
      escape_total     <= '0;
      req_inside_total <= '0;
      refused_total    <= '0;
    end else if (fire) begin
      busy             <= busy_next;
      escape_pending   <= escape_pending_next;
      ack_seen         <= ack_seen_next;
      byte_count       <= byte_count_next;
      received_total   <= received_total_next;
      dropped_total    <= dropped_total_next;
      escape_total     <= escape_total_next;
      req_inside_total <= req_inside_total_next;
      refused_total    <= refused_total_next;
    end
  end

endmodule

/* hdl/serial_packet_deframer.sv */
// ----------------------------------------------------------------------------
// serial_packet_deframer
// Escape-coded serial byte deframer with request/ack handshaking codes.
//
//   channel  | signals                           | direction
//   item     | item_valid, item_stall, item      | in
//   result   | result_valid, result_stall, result| out
//   config   | psel penable pwrite paddr pwdata  | in, prdata pready out
//
// One request per cycle sustained while result_stall is low; a request goes
// from the input register through the decode logic, which updates state and
// loads the result register in the same cycle. Reset clears state and loads
// the default codes. A stalled result holds both registers; item_stall rises
// only while the input register is full and cannot advance.
// ----------------------------------------------------------------------------
`include "serial_packet_deframer_assert.svh"

module serial_packet_deframer
  import spd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  spd_item_t   item,
  output logic        result_valid,
  input  logic        result_stall,
  output spd_result_t result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  spd_codes_t  codes;
  spd_item_t   stage;
  logic        stage_valid;
  logic        load_ok;
  logic        fire;
  spd_result_t res;

  spd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .codes   (codes)
  );

  spd_core u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .codes (codes),
    .item  (stage),
    .res   (res)
  );

  assign load_ok    = !result_valid || !result_stall;
  assign fire       = stage_valid && load_ok;
  assign item_stall = stage_valid && !load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      stage <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_ok) begin
      result_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res;
    end
  end

  `SPD_ASSERT_IMP(a_stall_needs_stage, item_stall, stage_valid)
  `SPD_ASSERT_IMP(a_write_or_done, result_valid,
                  !(result.write_valid && result.packet_done))
  `SPD_ASSERT_IMP(a_ack_restarts, result_valid && result.send_ack, result.length == '0)
  `SPD_ASSERT_IMP(a_length_cap, result_valid, result.length <= MAX_PACKET)
  `SPD_ASSERT_IMP(a_idle_data_zero, result_valid && !result.write_valid,
                  result.data_byte == 8'd0)

endmodule
